// ===== hdl/ptct_pkg.sv =====
package ptct_pkg;

  // Field widths, fixed by the item layout
  localparam int SAMPLE_BITS  = 16;
  localparam int TIME_BITS    = 16;
  localparam int INDEX_BITS   = 3;

  // Configuration register file
  localparam int NUM_REGS     = 8;
  localparam int REG_IDX_BITS = 3;
  localparam int LEVEL_COUNT_DEF = 8;

  // Reset levels of threshold_a .. threshold_h
  localparam int LEVEL_RESET [NUM_REGS] = '{3, 33, 66, 98, 131, 164, 328, 492};

  // Record kinds
  localparam logic KIND_CROSS = 1'b0;
  localparam logic KIND_PEAK  = 1'b1;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_value;
    logic [TIME_BITS-1:0]          sample_time;
    logic                          pulse_end;
  } in_item_t;

  typedef struct packed {
    logic                          record_kind;
    logic [INDEX_BITS-1:0]         level_index;
    logic                          was_crossed;
    logic [TIME_BITS-1:0]          event_time;
    logic signed [SAMPLE_BITS-1:0] peak_amplitude;
    logic                          final_record;
  } out_item_t;

  // Contents of one discriminator cell, handed down the chain on drain
  typedef struct packed {
    logic                 crossed;
    logic [TIME_BITS-1:0] moment;
  } cross_t;

  // Running peak of the current pulse
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] value;
    logic [TIME_BITS-1:0]          moment;
  } peak_t;

endpackage

// ===== hdl/peak_and_threshold_crossing_timer.sv =====
// Leading-edge discriminator with peak hold.
// Input channel (in_valid/in_ready/in_item): one shaper sample per item with
// its timestamp and an end-of-pulse mark. Samples are taken one per cycle while the block is not draining.
// Each of LEVEL_COUNT discriminator cells latches the time of the first
// sample strictly above its level; a peak cell keeps the pulse maximum.
// On the item marked pulse_end, the block drains: LEVEL_COUNT crossing
// records in level order, then one peak record (final_record = 1), on the
// output channel (out_valid/out_ready/out_item) through an output register.
// The drain shifts the cells down the chain, one record per cycle while the
// receiver does not stall; the first record enters the output register once
// the state register has entered the drain state after the end item is accepted.
// in_ready is low while the block drains, including every cycle the
// receiver stalls the burst; input is taken again while the peak record
// still waits in the output register.
// Configuration (cfg_we/cfg_index/cfg_data) writes a level.
// Reset (rst_n, synchronous) restores default levels and clears the pulse.
module peak_and_threshold_crossing_timer #(
  parameter int LEVEL_COUNT = ptct_pkg::LEVEL_COUNT_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  ptct_pkg::in_item_t                      in_item,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output ptct_pkg::out_item_t                     out_item,
  input  logic                                    cfg_we,
  input  logic [ptct_pkg::REG_IDX_BITS-1:0]       cfg_index,
  input  logic signed [ptct_pkg::SAMPLE_BITS-1:0] cfg_data
);
  import ptct_pkg::*;

  localparam int CNT_W = $clog2(LEVEL_COUNT + 1);

  typedef enum logic {ST_RUN, ST_DRAIN} state_t;

  state_t     state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_item_r, out_item_nxt;

  logic signed [SAMPLE_BITS-1:0] thr_r [LEVEL_COUNT];
  cross_t     cell_q [LEVEL_COUNT];
  peak_t      peak_q;
  logic       in_acc;
  logic       load_ok;
  logic       shift_en;
  logic       peak_clear;

  // Level registers
  always_ff @(posedge clk) begin
    for (int i = 0; i < LEVEL_COUNT; i++) begin
      if (!rst_n) begin
        thr_r[i] <= SAMPLE_BITS'(LEVEL_RESET[i]);
      end else if (cfg_we && (cfg_index == REG_IDX_BITS'(i))) begin
        thr_r[i] <= cfg_data;
      end
    end
  end

  assign in_ready = (state_r == ST_RUN);
  assign in_acc   = in_valid && in_ready;
  assign load_ok  = !out_valid_r || out_ready;

  // Discriminator chain; cell 0 feeds the output, the last cell takes zeros
  for (genvar g = 0; g < LEVEL_COUNT; g++) begin : g_cell
    cross_t nbr;
    if (g == LEVEL_COUNT - 1) begin : g_end
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cell_q[g+1];
    end
    ptct_level_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .threshold    (thr_r[g]),
      .sample_value (in_item.sample_value),
      .sample_time  (in_item.sample_time),
      .sample_en    (in_acc),
      .shift_en     (shift_en),
      .nbr_in       (nbr),
      .cell_out     (cell_q[g])
    );
  end

  ptct_peak_cell u_peak (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_value (in_item.sample_value),
    .sample_time  (in_item.sample_time),
    .sample_en    (in_acc),
    .clear        (peak_clear),
    .peak         (peak_q)
  );

  // Drain sequencer and output register load
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r && !out_ready;
    shift_en      = 1'b0;
    peak_clear    = 1'b0;
    case (state_r)
      ST_RUN: begin
        if (in_acc && in_item.pulse_end) begin
          state_nxt = ST_DRAIN;
          cnt_nxt   = '0;
        end
      end
      ST_DRAIN: begin
        if (load_ok) begin
          out_valid_nxt = 1'b1;
          if (cnt_r < CNT_W'(LEVEL_COUNT)) begin
            out_item_nxt.record_kind    = KIND_CROSS;
            out_item_nxt.level_index    = INDEX_BITS'(cnt_r);
            out_item_nxt.was_crossed    = cell_q[0].crossed;
            out_item_nxt.event_time     = cell_q[0].crossed ? cell_q[0].moment : '0;
            out_item_nxt.peak_amplitude = '0;
            out_item_nxt.final_record   = 1'b0;
            shift_en = 1'b1;
            cnt_nxt  = cnt_r + 1'b1;
          end else begin
            out_item_nxt.record_kind    = KIND_PEAK;
            out_item_nxt.level_index    = '0;
            out_item_nxt.was_crossed    = 1'b0;
            out_item_nxt.event_time     = peak_q.moment;
            out_item_nxt.peak_amplitude = peak_q.value;
            out_item_nxt.final_record   = 1'b1;
            peak_clear = 1'b1;
            cnt_nxt    = '0;
            state_nxt  = ST_RUN;
          end
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== hdl/ptct_level_cell.sv =====
module ptct_level_cell (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic signed [ptct_pkg::SAMPLE_BITS-1:0] threshold,
  input  logic signed [ptct_pkg::SAMPLE_BITS-1:0] sample_value,
  input  logic [ptct_pkg::TIME_BITS-1:0]          sample_time,
  input  logic                                    sample_en,
  input  logic                                    shift_en,
  input  ptct_pkg::cross_t                        nbr_in,
  output ptct_pkg::cross_t                        cell_out
);
  import ptct_pkg::*;

  logic                 crossed_r;
  logic [TIME_BITS-1:0] moment_r;

  // Crossed flag: latch on first sample above level, or take neighbor on drain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crossed_r <= 1'b0;
    end else if (shift_en) begin
      crossed_r <= nbr_in.crossed;
    end else if (sample_en && !crossed_r && (sample_value > threshold)) begin
      crossed_r <= 1'b1;
    end
  end

  // Crossing time, no reset needed (only read while flag is set)
  always_ff @(posedge clk) begin
    if (shift_en) begin
      moment_r <= nbr_in.moment;
    end else if (sample_en && !crossed_r && (sample_value > threshold)) begin
      moment_r <= sample_time;
    end
  end

  assign cell_out.crossed = crossed_r;
  assign cell_out.moment  = moment_r;

endmodule

// ===== hdl/ptct_peak_cell.sv =====
module ptct_peak_cell (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic signed [ptct_pkg::SAMPLE_BITS-1:0] sample_value,
  input  logic [ptct_pkg::TIME_BITS-1:0]          sample_time,
  input  logic                                    sample_en,
  input  logic                                    clear,
  output ptct_pkg::peak_t                         peak
);
  import ptct_pkg::*;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic signed [SAMPLE_BITS-1:0] value_r;
  logic [TIME_BITS-1:0]          moment_r;

  // Strictly greater replaces, so ties keep the earlier time
  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      value_r  <= SAMPLE_MIN;
      moment_r <= '0;
    end else if (sample_en && (sample_value > value_r)) begin
      value_r  <= sample_value;
      moment_r <= sample_time;
    end
  end

  assign peak.value  = value_r;
  assign peak.moment = moment_r;

endmodule
